[design/qfs_pkg.sv]
// Package for the quoted field splitter: character codes, result kinds,
// error codes, parser state and result types.
// No dependencies.
package qfs_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_BLANK  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam logic [7:0] SEP_RESET = 8'd44;

	// result queue depth, power of two
	localparam int FIFO_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_CELL = 2'd1,
		KIND_LINE = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE             = 2'd0,
		ERR_TEXT_AFTER_STR   = 2'd1,
		ERR_QUOTE_AFTER_TEXT = 2'd2,
		ERR_UNTERMINATED     = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CC_NONE   = 2'd0,
		CC_STRING = 2'd1,
		CC_PLAIN  = 2'd2
	} content_t;

	typedef struct packed {
		logic       inq;
		content_t   cck;
		logic       pq;
		logic       pb;
		logic       lhb;
		logic       drop;
	} st_t;

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		err_t       error_code;
		logic       last_of_run;
	} res_t;

	// results from one byte toward the result queue
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

[design/qfs_if.sv]
// Handshake channels of the quoted field splitter: raw text in, results out.
// Depends on qfs_pkg.
interface qfs_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source(output valid, output char_in, input ready);
	modport sink(input valid, input char_in, output ready);
endinterface

interface qfs_result_if;
	import qfs_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	kind_t      kind;
	err_t       error_code;
	logic       last_of_run;

	modport source(output valid, output out_byte, output kind, output error_code,
		output last_of_run, input ready);
	modport sink(input valid, input out_byte, input kind, input error_code,
		input last_of_run, output ready);
endinterface

[design/qfs_parse.sv]
// Input register, separator register, parser state and the per-byte
// decode that yields up to two results. Depends on qfs_pkg, qfs_if.
module qfs_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sep_we,
	input  logic [7:0]        sep_wdata,
	qfs_text_if.sink          text,
	input  logic              room,
	output qfs_pkg::push_t    push
);
	import qfs_pkg::*;

	typedef struct packed {
		logic hit;
		res_t r;
		st_t  st;
	} step_t;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic [7:0] sep_q;
	st_t        st_q;
	st_t        nx;
	res_t       r0, r1;
	logic [1:0] n;
	logic       fire;

	function automatic res_t byte_res(logic [7:0] c);
		res_t r;
		r = '0;
		r.out_byte = c;
		r.kind = KIND_BYTE;
		return r;
	endfunction

	function automatic res_t mark_res(kind_t k);
		res_t r;
		r = '0;
		r.kind = k;
		return r;
	endfunction

	function automatic res_t err_res(err_t e);
		res_t r;
		r = '0;
		r.kind = KIND_ERR;
		r.error_code = e;
		return r;
	endfunction

	function automatic step_t raise(step_t o, err_t e);
		step_t t;
		t = o;
		t.hit = 1'b1;
		t.r = err_res(e);
		t.st.inq = 1'b0;
		t.st.cck = CC_NONE;
		t.st.pq = 1'b0;
		t.st.pb = 1'b0;
		t.st.drop = 1'b1;
		return t;
	endfunction

	function automatic step_t do_outside(logic [7:0] c, logic [7:0] sep, st_t s);
		step_t o;
		o.hit = 1'b0;
		o.r = '0;
		o.st = s;
		// separator is tested first, even if it is a blank or a quote
		if (c == sep) begin
			o.hit = 1'b1;
			o.r = mark_res(KIND_CELL);
			o.st.cck = CC_NONE;
		end else if (c == CH_BLANK || c == CH_TAB) begin
			o.hit = 1'b0;
		end else if (s.cck == CC_STRING) begin
			o = raise(o, ERR_TEXT_AFTER_STR);
		end else if (c == CH_QUOTE) begin
			if (s.cck == CC_PLAIN) begin
				o = raise(o, ERR_QUOTE_AFTER_TEXT);
			end else begin
				o.st.inq = 1'b1;
				o.st.cck = CC_STRING;
			end
		end else begin
			o.hit = 1'b1;
			o.r = byte_res(c);
			o.st.cck = CC_PLAIN;
		end
		return o;
	endfunction

	function automatic step_t do_inside(logic [7:0] c, st_t s);
		step_t o;
		o.hit = 1'b0;
		o.r = '0;
		o.st = s;
		if (c == CH_QUOTE) begin
			o.st.pq = 1'b1;
		end else if (c == CH_BSLASH) begin
			o.st.pb = 1'b1;
		end else begin
			o.hit = 1'b1;
			o.r = byte_res(c);
		end
		return o;
	endfunction

	assign fire = valid_s1 && room;
	assign text.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sep_q <= SEP_RESET;
			st_q <= '0;
		end else begin
			if (sep_we) begin
				sep_q <= sep_wdata;
			end
			if (text.ready) begin
				valid_s1 <= text.valid;
			end
			if (fire) begin
				st_q <= nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			char_s1 <= text.char_in;
		end
	end

	always_comb begin
		step_t o;
		st_t   s;
		o = '0;
		s = st_q;
		nx = st_q;
		r0 = '0;
		r1 = '0;
		n = 2'd0;
		if (char_s1 == CH_NL) begin
			if (st_q.drop) begin
				n = 2'd0;
			end else if (st_q.pb) begin
				r0 = byte_res(CH_BSLASH);
				r1 = err_res(ERR_UNTERMINATED);
				n = 2'd2;
			end else if (st_q.pq) begin
				// pending quote closes the string
				r0 = mark_res(KIND_LINE);
				n = 2'd1;
			end else if (st_q.inq) begin
				r0 = err_res(ERR_UNTERMINATED);
				n = 2'd1;
			end else if (st_q.lhb) begin
				r0 = mark_res(KIND_LINE);
				n = 2'd1;
			end
			nx = '0;
		end else begin
			s.lhb = 1'b1;
			nx = s;
			if (s.drop) begin
				n = 2'd0;
			end else if (s.pq) begin
				s.pq = 1'b0;
				if (char_s1 == CH_QUOTE) begin
					nx = s;
					r0 = byte_res(CH_QUOTE);
					n = 2'd1;
				end else begin
					s.inq = 1'b0;
					o = do_outside(char_s1, sep_q, s);
					nx = o.st;
					r0 = o.r;
					n = {1'b0, o.hit};
				end
			end else if (s.pb) begin
				s.pb = 1'b0;
				nx = s;
				if (char_s1 == CH_N) begin
					r0 = byte_res(CH_NL);
					n = 2'd1;
				end else if (char_s1 == CH_T) begin
					r0 = byte_res(CH_TAB);
					n = 2'd1;
				end else begin
					// literal backslash, then the byte as a string byte
					o = do_inside(char_s1, s);
					nx = o.st;
					r0 = byte_res(CH_BSLASH);
					r1 = o.r;
					n = o.hit ? 2'd2 : 2'd1;
				end
			end else if (s.inq) begin
				o = do_inside(char_s1, s);
				nx = o.st;
				r0 = o.r;
				n = {1'b0, o.hit};
			end else begin
				o = do_outside(char_s1, sep_q, s);
				nx = o.st;
				r0 = o.r;
				n = {1'b0, o.hit};
			end
		end
		if (n == 2'd1) begin
			r0.last_of_run = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last_of_run = 1'b1;
		end
	end

	assign push.n  = fire ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r0.kind == KIND_BYTE && !push.r0.last_of_run
			&& push.r1.last_of_run)
		else $error("two-result transfer with bad ordering");

	a_line_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && char_s1 == CH_NL |=> !st_q.inq && !st_q.drop && !st_q.lhb
			&& !st_q.pq && !st_q.pb)
		else $error("line end left parser state set");

	a_err_drops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && char_s1 != CH_NL && n != 2'd0
			&& ((n == 2'd1 && r0.kind == KIND_ERR) || (n == 2'd2 && r1.kind == KIND_ERR))
		|=> st_q.drop)
		else $error("error did not start dropping");

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && st_q.drop |-> n == 2'd0)
		else $error("result while dropping after error");

endmodule

[design/qfs_res_fifo.sv]
// Small result queue: takes up to two results per cycle from the parser,
// hands one per cycle to a ready output. Depends on qfs_pkg, qfs_if.
module qfs_res_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  qfs_pkg::push_t    push,
	output logic              room,
	qfs_result_if.source      result
);
	import qfs_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	logic [PTR_W-1:0] wr_next;

	assign pop = result.valid && result.ready;
	assign room = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign wr_next = wr_q + PTR_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + PTR_W'(push.n);
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_next] <= push.r1;
		end
	end

	assign result.valid       = count_q != '0;
	assign result.out_byte    = mem_q[rd_q].out_byte;
	assign result.kind        = mem_q[rd_q].kind;
	assign result.error_code  = mem_q[rd_q].error_code;
	assign result.last_of_run = mem_q[rd_q].last_of_run;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("push without room");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push.n == 2'd0 |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("count did not drop on transfer");

endmodule

[design/quoted_field_splitter.sv]
// Top level of the quoted field splitter: parser plus result queue.
// Depends on qfs_pkg, qfs_if, qfs_parse, qfs_res_fifo.
//
// Splits a text stream into cells, one raw byte per transfer. A byte is
// taken every cycle while the queue has room; it sits in the input
// register, where the parser decodes it against the line state and pushes
// zero, one or two results into a four-entry result queue. The output
// side drains one result per cycle while the output is ready, so sustained
// input rate is one byte per cycle as long as bytes give at most one
// result on average; each two-result byte (a string backslash, then a byte
// other than n, t, quote or backslash) adds a result, and input stalls
// once the queue holds more than two results. The separator (reset ',') is
// written via sep_we/sep_wdata while the block is idle (user-enforced).
module quoted_field_splitter (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         sep_we,
	input  logic [7:0]   sep_wdata,
	qfs_text_if.sink     text,
	qfs_result_if.source result
);
	import qfs_pkg::*;

	push_t push;
	logic  room;

	qfs_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.sep_we    (sep_we),
		.sep_wdata (sep_wdata),
		.text      (text),
		.room      (room),
		.push      (push)
	);

	qfs_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

endmodule
